@@ rtl/block_sorter_with_swap_count_defines.svh @@
// ----------------------------------------------------------------------------
// Block sorter assertion macros
// Shorthand for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef BLOCK_SORTER_WITH_SWAP_COUNT_DEFINES_SVH
`define BLOCK_SORTER_WITH_SWAP_COUNT_DEFINES_SVH

// Same-cycle implication, checked while the block is out of reset.
`define BSSWC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while the block is out of reset.
`define BSSWC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bsswc_pkg.sv @@
// ----------------------------------------------------------------------------
// Block sorter package
// Shared widths, codes and control structures of the block sorter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsswc_pkg;

    localparam int VALUE_W     = 32;
    localparam int SWAP_W      = 11;
    localparam logic [SWAP_W-1:0] SWAP_MAX = 11'd2047;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 48;
    localparam int M_PAD_W     = M_TDATA_W - VALUE_W - SWAP_W;
    localparam int GROUP_SIZE  = 8;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_SORT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     pair_en;
    } cell_ctrl_t;

    typedef struct packed {
        logic clear;
        logic sample;
    } cnt_ctrl_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ALIGN,
        ST_SORT,
        ST_DRAIN,
        ST_OUT
    } sorter_state_t;

endpackage

`default_nettype wire

@@ rtl/bsswc_cell.sv @@
// ----------------------------------------------------------------------------
// Block sorter cell
// One element slot of the sorting chain: shifts, holds or swaps its value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsswc_cell
    import bsswc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cell_ctrl_t                ctrl,
    input  wire logic signed [VALUE_W-1:0] lower_value,
    input  wire logic                      lower_valid,
    input  wire logic signed [VALUE_W-1:0] upper_value,
    input  wire logic                      upper_valid,
    input  wire logic                      swap_down,
    output logic signed [VALUE_W-1:0]      value,
    output logic                           valid,
    output logic                           swap_up
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      valid_reg;
    logic                      valid_next;

    // The lower cell of a pair decides the exchange for both members.
    assign swap_up = (ctrl.op == CELL_SORT) && ctrl.pair_en && valid_reg && upper_valid
                     && (upper_value > value_reg);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            CELL_SHIFT:
            begin
                value_next = lower_value;
                valid_next = lower_valid;
            end
            CELL_SORT:
            begin
                if (swap_up)
                begin
                    value_next = upper_value;
                end
                else if (swap_down)
                begin
                    value_next = lower_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

@@ rtl/bsswc_swap_counter.sv @@
// ----------------------------------------------------------------------------
// Block sorter swap counter
// Pipelined population count of the exchange flags, with a saturating total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsswc_swap_counter
    import bsswc_pkg::*;
#(
    parameter int NFLAGS = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cnt_ctrl_t         ctrl,
    input  wire logic [NFLAGS-1:0] flags,
    output logic [SWAP_W-1:0]      total,
    output logic                   busy
);

    localparam int NGRP  = (NFLAGS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_W = NGRP * GROUP_SIZE;
    localparam int GRP_W = $clog2(GROUP_SIZE + 1);
    localparam int SUM_W = $clog2(NFLAGS + 1);

    logic [NFLAGS-1:0] flag_reg;
    logic              flag_vld_reg;
    logic [GRP_W-1:0]  grp_reg  [NGRP];
    logic [GRP_W-1:0]  grp_next [NGRP];
    logic              grp_vld_reg;
    logic [SWAP_W-1:0] total_reg;
    logic [SWAP_W-1:0] total_next;
    logic [PAD_W-1:0]  flag_pad;
    logic [SUM_W-1:0]  grp_total;
    logic [SWAP_W:0]   acc_sum;

    assign flag_pad = PAD_W'(flag_reg);

    // First stage: count each group of eight flags.
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int b = 0; b < GROUP_SIZE; b++)
            begin
                grp_next[g] = grp_next[g] + GRP_W'(flag_pad[g*GROUP_SIZE + b]);
            end
        end
    end

    // Second stage: add the group counts and accumulate with saturation.
    always_comb
    begin
        grp_total = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            grp_total = grp_total + SUM_W'(grp_reg[g]);
        end
        acc_sum = {1'b0, total_reg} + (SWAP_W + 1)'(grp_total);
        if (ctrl.clear)
        begin
            total_next = '0;
        end
        else if (grp_vld_reg)
        begin
            total_next = (acc_sum > {1'b0, SWAP_MAX}) ? SWAP_MAX : acc_sum[SWAP_W-1:0];
        end
        else
        begin
            total_next = total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_vld_reg <= 1'b0;
            grp_vld_reg  <= 1'b0;
            total_reg    <= '0;
        end
        else
        begin
            flag_vld_reg <= ctrl.sample;
            grp_vld_reg  <= flag_vld_reg;
            total_reg    <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flag_reg <= flags;
        for (int g = 0; g < NGRP; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
    end

    assign total = total_reg;
    assign busy  = flag_vld_reg || grp_vld_reg;

endmodule

`default_nettype wire

@@ rtl/block_sorter_with_swap_count.sv @@
// ----------------------------------------------------------------------------
// Block sorter with swap count
// Sorts a block of signed values ascending and reports the number of
// adjacent exchanges (the inversion count) with every sorted value.
// ----------------------------------------------------------------------------
// A block of up to MAX_ITEMS signed 32-bit values is loaded one transaction
// per cycle on the slave stream; tlast ends the block. Values arriving once
// the block is full are dropped and the overflow flag (m_tuser) is set for
// that block, though a dropped transaction carrying tlast still ends it.
// After the last input transaction the block moves the n held values to the
// top of the cell chain (the final align step only sees that the oldest
// value has arrived), sorts them across the chain by odd-even transposition,
// and waits for the swap-count pipeline to settle. The sorted values then
// leave on the master stream one per cycle while the receiver is ready,
// smallest first, each carrying the total swap count; tlast marks the final
// one. Input is not accepted while a block is being sorted or emitted, but
// the next block may start loading while the final result still waits in
// the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module block_sorter_with_swap_count
    import bsswc_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Slave stream.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
    input  wire logic                 s_tlast,   // last_item
    // Master stream.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [31:0] sorted_value, [42:32] swap_count
    output logic                      m_tuser,   // overflow
    output logic                      m_tlast    // last_result
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    sorter_state_t state_reg;
    sorter_state_t state_next;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] phase_reg;
    logic [CNT_W-1:0] phase_next;
    logic             dropped_reg;
    logic             dropped_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic signed [VALUE_W-1:0] out_value_next;
    logic [SWAP_W-1:0]         out_swap_reg;
    logic [SWAP_W-1:0]         out_swap_next;
    logic                      out_ovf_reg;
    logic                      out_ovf_next;
    logic                      out_last_reg;
    logic                      out_last_next;

    logic                      s_fire;
    logic                      full;
    logic                      out_load;
    cell_op_t                  cell_op;
    logic                      feed_valid;
    logic signed [VALUE_W-1:0] feed_value;

    logic signed [VALUE_W-1:0] cell_value [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]      cell_valid;
    logic [MAX_ITEMS-1:0]      swap_flag;

    cnt_ctrl_t         cnt_ctrl;
    logic [SWAP_W-1:0] swap_total;
    logic              cnt_busy;

    assign full       = (count_reg >= CNT_W'(MAX_ITEMS));
    assign s_fire     = s_tvalid && s_tready;
    assign feed_value = $signed(s_tdata[VALUE_W-1:0]);

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_fire && s_tlast)
                begin
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN:
            begin
                // The block is aligned once the oldest value reaches the top cell.
                if (cell_valid[MAX_ITEMS-1])
                begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT:
            begin
                if (phase_reg == count_reg - CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!cnt_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load && (count_reg == CNT_W'(1)))
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs to the chain, the counter and the handshakes.
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready       = 1'b0;
        out_load       = 1'b0;
        cell_op        = CELL_HOLD;
        feed_valid     = 1'b0;
        cnt_ctrl.clear  = 1'b0;
        cnt_ctrl.sample = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready       = 1'b1;
                feed_valid     = 1'b1;
                cnt_ctrl.clear = 1'b1;
                if (s_fire && !full)
                begin
                    cell_op = CELL_SHIFT;
                end
            end
            ST_ALIGN:
            begin
                if (!cell_valid[MAX_ITEMS-1])
                begin
                    cell_op = CELL_SHIFT;
                end
            end
            ST_SORT:
            begin
                cell_op         = CELL_SORT;
                cnt_ctrl.sample = 1'b1;
            end
            ST_DRAIN:
            begin
                cell_op = CELL_HOLD;
            end
            ST_OUT:
            begin
                out_load = !out_valid_reg || m_tready;
                if (out_load)
                begin
                    cell_op = CELL_SHIFT;
                end
            end
            default:
            begin
                cell_op = CELL_HOLD;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Block bookkeeping and the output register.
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_swap_next  = out_swap_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;

        if ((state_reg == ST_LOAD) && s_fire)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end

        if (state_reg == ST_ALIGN)
        begin
            phase_next = '0;
        end
        else if (state_reg == ST_SORT)
        begin
            phase_next = phase_reg + CNT_W'(1);
        end

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // In the output phase count_reg counts the values still held.
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_value_next = cell_value[MAX_ITEMS-1];
            out_swap_next  = swap_total;
            out_ovf_next   = dropped_reg;
            out_last_next  = (count_reg == CNT_W'(1));
            count_next     = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            phase_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_swap_reg  <= out_swap_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    // ------------------------------------------------------------------
    // Cell chain. New values enter cell 0 and move upward, so the oldest
    // value sits highest. Ascending order of the block means descending
    // order up the chain, and the smallest value leaves from the top cell.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        localparam logic CELL_ODD = 1'((i % 2) != 0);

        cell_ctrl_t                ctrl;
        logic signed [VALUE_W-1:0] lower_value;
        logic                      lower_valid;
        logic signed [VALUE_W-1:0] upper_value;
        logic                      upper_valid;
        logic                      swap_down;

        assign ctrl.op = cell_op;

        if (i == 0)
        begin : g_bottom
            assign lower_value = feed_value;
            assign lower_valid = feed_valid;
            assign swap_down   = 1'b0;
        end
        else
        begin : g_inner_low
            assign lower_value = cell_value[i-1];
            assign lower_valid = cell_valid[i-1];
            assign swap_down   = swap_flag[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_top
            assign upper_value  = '0;
            assign upper_valid  = 1'b0;
            assign ctrl.pair_en = 1'b0;
        end
        else
        begin : g_inner_high
            assign upper_value  = cell_value[i+1];
            assign upper_valid  = cell_valid[i+1];
            // Pairs alternate between even and odd lower cells each phase.
            assign ctrl.pair_en = (CELL_ODD == phase_reg[0]);
        end

        bsswc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .lower_value (lower_value),
            .lower_valid (lower_valid),
            .upper_value (upper_value),
            .upper_valid (upper_valid),
            .swap_down   (swap_down),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .swap_up     (swap_flag[i])
        );
    end

    bsswc_swap_counter #(
        .NFLAGS (MAX_ITEMS)
    ) u_swap_counter (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cnt_ctrl),
        .flags (swap_flag),
        .total (swap_total),
        .busy  (cnt_busy)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {M_PAD_W'(0), out_swap_reg, out_value_reg};
    assign m_tuser  = out_ovf_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/bsswc_checker.sv @@
// ----------------------------------------------------------------------------
// Block sorter checker
// Port-level assertions on the sorted output stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "block_sorter_with_swap_count_defines.svh"

module bsswc_checker
    import bsswc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tready,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 m_tuser,
    input  wire logic                 m_tlast
);

    logic                      out_fire;
    logic                      mid_reg;
    logic signed [VALUE_W-1:0] prev_value_reg;
    logic [SWAP_W-1:0]         prev_swap_reg;
    logic                      prev_ovf_reg;

    assign out_fire = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg        <= 1'b0;
            prev_value_reg <= '0;
            prev_swap_reg  <= '0;
            prev_ovf_reg   <= 1'b0;
        end
        else if (out_fire)
        begin
            mid_reg        <= !m_tlast;
            prev_value_reg <= $signed(m_tdata[VALUE_W-1:0]);
            prev_swap_reg  <= m_tdata[VALUE_W+SWAP_W-1:VALUE_W];
            prev_ovf_reg   <= m_tuser;
        end
    end

    // A stalled result holds its payload.
    `BSSWC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // Within a block the values leave in ascending order.
    `BSSWC_ASSERT_IMP(a_ascending, out_fire && mid_reg, $signed(m_tdata[VALUE_W-1:0]) >= prev_value_reg, "sorted values out of order")

    // Swap count and overflow are the same on every result of a block.
    `BSSWC_ASSERT_IMP(a_block_const, out_fire && mid_reg, (m_tdata[VALUE_W+SWAP_W-1:VALUE_W] == prev_swap_reg) && (m_tuser == prev_ovf_reg), "block totals changed mid block")

    // No new block is taken while a block is still being emitted.
    `BSSWC_ASSERT_IMP(a_no_load_mid_output, m_tvalid && !m_tlast, !s_tready, "input accepted during output")

endmodule

bind block_sorter_with_swap_count bsswc_checker u_bsswc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ test/sorter_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block sorter stream checker
// Watches both streams of the block sorter, predicts the sorted block and its
// swap count from the accepted input, and compares every output transaction.
// ----------------------------------------------------------------------------

module sorter_checker
    import bsswc_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // [31:0] value
    input  logic                 s_tlast,    // last_item
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,    // [31:0] sorted_value, [42:32] swap_count
    input  logic                 m_tuser,    // overflow
    input  logic                 m_tlast,    // last_result
    output int                   failures,
    output int                   pending,
    output int                   loaded,
    output int                   blocks,
    output int                   overflow_blocks,
    output int                   results
);

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [SWAP_W-1:0]         swaps;
        logic                      overflow;
        logic                      last;
    } sorted_entry_t;

    logic signed [VALUE_W-1:0] block_values [$];
    logic                      block_dropped;
    sorted_entry_t             sorted_due [$];
    sorted_entry_t             due_head;

    initial
    begin
        block_dropped   = 1'b0;
        failures        = 0;
        pending         = 0;
        loaded          = 0;
        blocks          = 0;
        overflow_blocks = 0;
        results         = 0;
    end

    // Bubble sort of the held block; every exchange is counted, saturating.
    function automatic void bubble_sort_block();
        logic signed [VALUE_W-1:0] held [$];
        logic signed [VALUE_W-1:0] tmp;
        logic [SWAP_W-1:0]         swaps;
        sorted_entry_t             entry;
        held  = block_values;
        swaps = '0;
        for (int pass = 0; pass + 1 < held.size(); pass++)
        begin
            for (int k = 0; k + 1 < held.size(); k++)
            begin
                if (held[k] > held[k + 1])
                begin
                    tmp         = held[k];
                    held[k]     = held[k + 1];
                    held[k + 1] = tmp;
                    if (swaps != SWAP_MAX)
                        swaps++;
                end
            end
        end
        foreach (held[k])
        begin
            entry.value    = held[k];
            entry.swaps    = swaps;
            entry.overflow = block_dropped;
            entry.last     = (k == held.size() - 1);
            sorted_due.push_back(entry);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                loaded++;
                if (block_values.size() < CAPACITY)
                    block_values.push_back(s_tdata[VALUE_W-1:0]);
                else
                    block_dropped = 1'b1;
                if (s_tlast)
                begin
                    blocks++;
                    if (block_dropped)
                        overflow_blocks++;
                    bubble_sort_block();
                    block_values.delete();
                    block_dropped = 1'b0;
                end
            end

            if (m_tvalid && m_tready)
            begin
                results++;
                if (sorted_due.size() == 0)
                begin
                    failures++;
                    $error("unexpected output transaction: sorted_value %0d",
                           $signed(m_tdata[VALUE_W-1:0]));
                end
                else
                begin
                    due_head = sorted_due.pop_front();
                    if (m_tdata[VALUE_W-1:0] !== due_head.value)
                    begin
                        failures++;
                        $error("sorted_value: expected %0d, got %0d",
                               due_head.value, $signed(m_tdata[VALUE_W-1:0]));
                    end
                    if (m_tdata[VALUE_W+SWAP_W-1:VALUE_W] !== due_head.swaps)
                    begin
                        failures++;
                        $error("swap_count: expected %0d, got %0d",
                               due_head.swaps, m_tdata[VALUE_W+SWAP_W-1:VALUE_W]);
                    end
                    if (m_tuser !== due_head.overflow)
                    begin
                        failures++;
                        $error("overflow: expected %0b, got %0b", due_head.overflow, m_tuser);
                    end
                    if (m_tlast !== due_head.last)
                    begin
                        failures++;
                        $error("last_result: expected %0b, got %0b", due_head.last, m_tlast);
                    end
                end
            end

            pending = sorted_due.size();
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block sorter testbench
// Feeds blocks of signed values through the sorter under several idling
// patterns and lets the stream checker verify order, swap count and flags.
// ----------------------------------------------------------------------------

module testbench;

    import bsswc_pkg::*;

    localparam int MAX_ITEMS     = 64;
    localparam int RANDOM_ITEMS  = 370;
    localparam int CYCLE_LIMIT   = 200_000;
    // Worst block: realign, sort and settle, plus emitting a full block.
    localparam int SETTLE_CYCLES = 4 * MAX_ITEMS + 16;

    // Sizes of the occasional large blocks: exactly full, one and several
    // transactions over capacity, and just under.
    localparam int LARGE_SIZES [4] = '{64, 65, 70, 63};

    localparam logic [VALUE_W-1:0] EXTREMES [5] =
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};

    // How the values of one block are drawn.
    typedef enum int {
        VAL_RANDOM,
        VAL_NARROW,
        VAL_EXTREME,
        VAL_RISING,
        VAL_FALLING
    } value_style_t;

    // Handshake pressure for the four quarters of the random part.
    typedef enum int {
        PHASE_STEADY,
        PHASE_SENDER_IDLE,
        PHASE_RECEIVER_STALL,
        PHASE_BOTH_IDLE
    } idle_phase_t;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;     // [31:0] value
    logic                 s_tlast  = 1'b0;   // last_item
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;           // [31:0] sorted_value, [42:32] swap_count
    logic                 m_tuser;           // overflow
    logic                 m_tlast;           // last_result

    int idle_pct  = 0;
    int stall_pct = 0;
    int cycles    = 0;

    int failures;
    int pending;
    int loaded;
    int blocks;
    int overflow_blocks;
    int results;

    block_sorter_with_swap_count #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sorter_checker #(
        .CAPACITY (MAX_ITEMS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .failures        (failures),
        .pending         (pending),
        .loaded          (loaded),
        .blocks          (blocks),
        .overflow_blocks (overflow_blocks),
        .results         (results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver drops tready at random with the current stall rate; at a
    // rate of zero it accepts every output transaction as soon as it appears.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog. A correct run finishes before this limit, so hitting it
    // means the block has hung or lost results.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles, %0d results outstanding.",
                     cycles, pending);
            $display("** block_sorter_with_swap_count: FAILED **");
            $finish;
        end
    end

    // One input transaction. The sender may hold tvalid low for a random
    // number of cycles first; tvalid then stays high until tready is seen at
    // a rising edge, and is left high so a back-to-back transaction follows
    // without a bubble.
    task automatic send_item(input logic [VALUE_W-1:0] v, input logic last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // A whole block: tlast goes with the final transaction, even when the
    // block is longer than the sorter can hold.
    task automatic send_values(input logic [VALUE_W-1:0] vals [$]);
        foreach (vals[i])
            send_item(vals[i], i == vals.size() - 1);
    endtask

    // Rising and falling blocks start at the ends of the signed range and
    // step by at most 1000, so they never wrap even at the largest size.
    task automatic send_block(input int size, input value_style_t style);
        logic [VALUE_W-1:0] v;
        for (int i = 0; i < size; i++)
        begin
            case (style)
                VAL_RANDOM:  v = $urandom;
                VAL_NARROW:  v = $urandom_range(0, 8) - 4;
                VAL_EXTREME: v = EXTREMES[$urandom_range(0, 4)];
                VAL_RISING:  v = (i == 0) ? 32'h8000_0000 + $urandom_range(0, 1000)
                                          : v + $urandom_range(0, 1000);
                default:     v = (i == 0) ? 32'h7FFF_FFFF - $urandom_range(0, 1000)
                                          : v - $urandom_range(1, 1000);
            endcase
            send_item(v, i == size - 1);
        end
    endtask

    initial
    begin
        logic [VALUE_W-1:0] directed [$];
        idle_phase_t        phase;
        value_style_t       style;
        int                 size;
        int                 blk;
        int                 sent_random;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed blocks, no idling: a single value (the most negative),
        // the two extremes reversed, a run of equal values that must never
        // be swapped, extremes with a duplicate maximum, and an interleaved
        // block that needs many exchanges.
        directed = '{32'h8000_0000};
        send_values(directed);
        directed = '{32'h7FFF_FFFF, 32'h8000_0000};
        send_values(directed);
        directed = '{32'd7, 32'd7, 32'd7, 32'd7};
        send_values(directed);
        directed = '{32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                     32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF};
        send_values(directed);
        directed = '{32'd3, -32'sd3, 32'd2, -32'sd2, 32'd1, -32'sd1};
        send_values(directed);

        // Random blocks. Most are short; every eighth block is large so the
        // full-capacity and dropped-transaction paths get exercised, and the
        // falling large blocks, fully reversed, give a full block's largest swap count.
        blk         = 0;
        sent_random = 0;
        while (sent_random < RANDOM_ITEMS)
        begin
            phase = idle_phase_t'(sent_random * 4 / RANDOM_ITEMS);
            case (phase)
                PHASE_STEADY:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                PHASE_SENDER_IDLE:
                begin
                    idle_pct  = 53;
                    stall_pct = 0;
                end
                PHASE_RECEIVER_STALL:
                begin
                    idle_pct  = 0;
                    stall_pct = 53;
                end
                default:
                begin
                    idle_pct  = 15;
                    stall_pct = 15;
                end
            endcase

            if (blk % 8 == 5)
            begin
                size  = LARGE_SIZES[(blk / 8) % 4];
                style = ((blk / 8) % 2 == 0) ? VAL_FALLING : VAL_RANDOM;
            end
            else
            begin
                size  = $urandom_range(1, 12);
                style = value_style_t'($urandom_range(0, 4));
            end
            send_block(size, style);
            sent_random += size;
            blk++;
        end
        s_tvalid <= 1'b0;

        // Drain: every predicted result must arrive, then allow one more
        // block's worth of cycles for anything spurious to show up.
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sorted %0d blocks from %0d input transactions, %0d over capacity.",
                 blocks, loaded, overflow_blocks);
        $display("Checked %0d output transactions under four idling patterns.", results);
        if (failures == 0 && pending == 0)
            $display("** block_sorter_with_swap_count: PASSED **");
        else
            $display("** block_sorter_with_swap_count: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bsswc_pkg.sv
rtl/bsswc_cell.sv
rtl/bsswc_swap_counter.sv
rtl/block_sorter_with_swap_count.sv
rtl/bsswc_checker.sv
test/sorter_checker.sv
test/testbench.sv
